>>> design/imag_pkg.sv
package imag_pkg;

    // Sample axis width and the widths that follow from it
    localparam int AXIS_W    = 16;
    localparam int NUM_AXES  = 6;
    localparam int SUM_W     = 2 * AXIS_W;
    localparam int ROOT_W    = AXIS_W;
    localparam int REM_W     = AXIS_W + 2;
    localparam int CNT_W     = $clog2(AXIS_W);
    localparam int AXIS_IDX_W = 3;

    // Configuration port
    localparam int CFG_W      = 16;
    localparam int THR_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Score arithmetic
    localparam int DEV_W   = (AXIS_W > CFG_W) ? AXIS_W : CFG_W;
    localparam int SPROD_W = DEV_W + CFG_W;
    localparam int SCORE_W = SPROD_W + 1;

    // Conductance scaling: code * 3300 / 4095 == code * 220 / 273
    localparam int CODE_W    = 12;
    localparam int MV_W      = 12;
    localparam int MV_FULL   = 3300;
    localparam int CODE_FULL = 4095;
    localparam int MV_GCD    = 15;
    localparam int MV_NUM    = MV_FULL / MV_GCD;
    localparam int MV_DEN    = CODE_FULL / MV_GCD;
    localparam int CX_W      = 20;
    localparam int MV_SHIFT  = 29;
    localparam int MV_RECIP  = ((2 ** MV_SHIFT) + MV_DEN - 1) / MV_DEN;
    localparam int RECIP_W   = 21;
    localparam int CPROD_W   = CX_W + RECIP_W;

    // Register reset values
    localparam logic [CFG_W-1:0] GRAVITY_RST   = 16'd2050;
    localparam logic [CFG_W-1:0] ACCEL_W_RST   = 16'd3197;
    localparam logic [CFG_W-1:0] GYRO_W_RST    = 16'd1998;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 32'd524288;
    localparam logic [CFG_W-1:0] HOLDOFF_RST   = 16'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY   = 3'd0,
        REG_ACCEL_W   = 3'd1,
        REG_GYRO_W    = 3'd2,
        REG_THRESHOLD = 3'd3,
        REG_HOLDOFF   = 3'd4
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_RT_INIT,
        ST_RT,
        ST_DEV,
        ST_MUL_A,
        ST_MUL_G,
        ST_SUM,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                  load;
        logic                  sq_mul;
        logic                  sq_acc;
        logic [AXIS_IDX_W-1:0] sq_idx;
        logic                  rt_init;
        logic                  rt_step;
        logic                  dev;
        logic                  mul_a;
        logic                  mul_g;
        logic                  sum;
        logic                  commit;
    } t_dp_cmd;

endpackage

>>> design/imag_smp_if.sv
interface imag_smp_if;
    logic                                valid;
    logic                                ready;
    logic signed [imag_pkg::AXIS_W-1:0]  accel_x;
    logic signed [imag_pkg::AXIS_W-1:0]  accel_y;
    logic signed [imag_pkg::AXIS_W-1:0]  accel_z;
    logic signed [imag_pkg::AXIS_W-1:0]  rate_x;
    logic signed [imag_pkg::AXIS_W-1:0]  rate_y;
    logic signed [imag_pkg::AXIS_W-1:0]  rate_z;
    logic [imag_pkg::CODE_W-1:0]         conductance_code;

    modport source (
        output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, conductance_code,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, conductance_code,
        output ready
    );
endinterface

>>> design/imag_res_if.sv
interface imag_res_if;
    logic                      valid;
    logic                      ready;
    logic                      motion_hit;
    logic                      artifact_flag;
    logic [imag_pkg::CFG_W-1:0] holdoff_left;
    logic [imag_pkg::MV_W-1:0] conductance_mv;

    modport source (
        output valid, motion_hit, artifact_flag, holdoff_left, conductance_mv,
        input  ready
    );
    modport sink (
        input  valid, motion_hit, artifact_flag, holdoff_left, conductance_mv,
        output ready
    );
endinterface

>>> design/imag_ctrl.sv
module imag_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output imag_pkg::t_dp_cmd o_cmd
);

    imag_pkg::t_state               r_state, n_state;
    logic [imag_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                           r_out_valid, n_out_valid;

    // State, step counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imag_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Sequencing of one sample
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            imag_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = imag_pkg::ST_SQ;
                end
            end
            // one square per cycle, each accumulated in the next cycle
            imag_pkg::ST_SQ: begin
                o_cmd.sq_mul = (r_cnt < imag_pkg::CNT_W'(imag_pkg::NUM_AXES));
                o_cmd.sq_acc = (r_cnt != '0);
                o_cmd.sq_idx = r_cnt[imag_pkg::AXIS_IDX_W-1:0];
                if (r_cnt == imag_pkg::CNT_W'(imag_pkg::NUM_AXES)) begin
                    n_state = imag_pkg::ST_RT_INIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            imag_pkg::ST_RT_INIT: begin
                o_cmd.rt_init = 1'b1;
                n_cnt         = '0;
                n_state       = imag_pkg::ST_RT;
            end
            // one root bit per cycle
            imag_pkg::ST_RT: begin
                o_cmd.rt_step = 1'b1;
                if (r_cnt == imag_pkg::CNT_W'(imag_pkg::ROOT_W - 1)) begin
                    n_state = imag_pkg::ST_DEV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            imag_pkg::ST_DEV: begin
                o_cmd.dev = 1'b1;
                n_state   = imag_pkg::ST_MUL_A;
            end
            imag_pkg::ST_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = imag_pkg::ST_MUL_G;
            end
            imag_pkg::ST_MUL_G: begin
                o_cmd.mul_g = 1'b1;
                n_state     = imag_pkg::ST_SUM;
            end
            imag_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = imag_pkg::ST_DONE;
            end
            // wait for a free output register
            imag_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = imag_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = imag_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> design/imag_datapath.sv
module imag_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [imag_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [imag_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  imag_pkg::t_dp_cmd                 i_cmd,
    input  logic [imag_pkg::AXIS_W-1:0]       i_axis [imag_pkg::NUM_AXES],
    input  logic [imag_pkg::CODE_W-1:0]       i_code,
    output logic                              o_motion_hit,
    output logic                              o_artifact_flag,
    output logic [imag_pkg::CFG_W-1:0]        o_holdoff_left,
    output logic [imag_pkg::MV_W-1:0]         o_conductance_mv
);

    // Configuration registers
    logic [imag_pkg::CFG_W-1:0]   r_gravity;
    logic [imag_pkg::CFG_W-1:0]   r_accel_w;
    logic [imag_pkg::CFG_W-1:0]   r_gyro_w;
    logic [imag_pkg::THR_W-1:0]   r_threshold;
    logic [imag_pkg::CFG_W-1:0]   r_holdoff;
    logic [imag_pkg::CFG_W-1:0]   r_hcnt;

    // Per-sample working registers
    logic [imag_pkg::AXIS_W-1:0]  r_abs [imag_pkg::NUM_AXES];
    logic [imag_pkg::CODE_W-1:0]  r_code;
    logic [imag_pkg::SUM_W-1:0]   r_sq;
    logic [imag_pkg::SUM_W-1:0]   r_acc_a;
    logic [imag_pkg::SUM_W-1:0]   r_acc_g;
    logic [imag_pkg::SUM_W-1:0]   r_rad  [2];
    logic [imag_pkg::REM_W-1:0]   r_rem  [2];
    logic [imag_pkg::ROOT_W-1:0]  r_root [2];
    logic [imag_pkg::DEV_W-1:0]   r_dev;
    logic [imag_pkg::SPROD_W-1:0] r_sprod;
    logic [imag_pkg::SCORE_W-1:0] r_score;
    logic [imag_pkg::CX_W-1:0]    r_cx;
    logic [imag_pkg::MV_W-1:0]    r_cmv;

    // Output registers
    logic                         r_motion;
    logic                         r_artifact;
    logic [imag_pkg::CFG_W-1:0]   r_left;
    logic [imag_pkg::MV_W-1:0]    r_mv;

    logic [imag_pkg::AXIS_IDX_W-1:0] s_acc_idx;
    logic [imag_pkg::REM_W+1:0]   s_trem  [2];
    logic [imag_pkg::REM_W+1:0]   s_trial [2];
    logic                         s_ge    [2];
    logic [imag_pkg::DEV_W-1:0]   s_amag;
    logic [imag_pkg::DEV_W-1:0]   s_grav;
    logic                         s_motion;
    logic [imag_pkg::CFG_W-1:0]   s_hold;
    logic                         s_art;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= imag_pkg::GRAVITY_RST;
            r_accel_w   <= imag_pkg::ACCEL_W_RST;
            r_gyro_w    <= imag_pkg::GYRO_W_RST;
            r_threshold <= imag_pkg::THRESHOLD_RST;
            r_holdoff   <= imag_pkg::HOLDOFF_RST;
        end else if (i_cfg_we) begin
            case (imag_pkg::t_cfg_reg'(i_cfg_idx))
                imag_pkg::REG_GRAVITY:   r_gravity   <= i_cfg_data[imag_pkg::CFG_W-1:0];
                imag_pkg::REG_ACCEL_W:   r_accel_w   <= i_cfg_data[imag_pkg::CFG_W-1:0];
                imag_pkg::REG_GYRO_W:    r_gyro_w    <= i_cfg_data[imag_pkg::CFG_W-1:0];
                imag_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data[imag_pkg::THR_W-1:0];
                imag_pkg::REG_HOLDOFF:   r_holdoff   <= i_cfg_data[imag_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample capture, axis magnitudes taken on the way in
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < imag_pkg::NUM_AXES; k++) begin
                r_abs[k] <= i_axis[k][imag_pkg::AXIS_W-1] ? (~i_axis[k] + 1'b1) : i_axis[k];
            end
            r_code <= i_code;
        end
    end

    // Sums of squares: shared squarer, registered, then accumulated
    assign s_acc_idx = i_cmd.sq_idx - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc_a <= '0;
            r_acc_g <= '0;
        end else begin
            if (i_cmd.sq_mul) begin
                r_sq <= imag_pkg::SUM_W'(r_abs[i_cmd.sq_idx]) *
                        imag_pkg::SUM_W'(r_abs[i_cmd.sq_idx]);
            end
            if (i_cmd.sq_acc) begin
                if (s_acc_idx < imag_pkg::AXIS_IDX_W'(3)) begin
                    r_acc_a <= r_acc_a + r_sq;
                end else begin
                    r_acc_g <= r_acc_g + r_sq;
                end
            end
        end
    end

    // Two digit-by-digit square root units, one result bit per cycle
    always_comb begin
        for (int u = 0; u < 2; u++) begin
            s_trem[u]  = {r_rem[u], r_rad[u][imag_pkg::SUM_W-1 -: 2]};
            s_trial[u] = (imag_pkg::REM_W+2)'({r_root[u], 2'b01});
            s_ge[u]    = (s_trem[u] >= s_trial[u]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rt_init) begin
            r_rad[0] <= r_acc_a;
            r_rad[1] <= r_acc_g;
            for (int u = 0; u < 2; u++) begin
                r_rem[u]  <= '0;
                r_root[u] <= '0;
            end
        end else if (i_cmd.rt_step) begin
            for (int u = 0; u < 2; u++) begin
                r_rad[u]  <= {r_rad[u][imag_pkg::SUM_W-3:0], 2'b00};
                r_rem[u]  <= s_ge[u] ? imag_pkg::REM_W'(s_trem[u] - s_trial[u])
                                     : imag_pkg::REM_W'(s_trem[u]);
                r_root[u] <= {r_root[u][imag_pkg::ROOT_W-2:0], s_ge[u]};
            end
        end
    end

    // Deviation from gravity, then weighted score: accel and gyro products, summed
    assign s_amag = imag_pkg::DEV_W'(r_root[0]);
    assign s_grav = imag_pkg::DEV_W'(r_gravity);

    always_ff @(posedge i_clk) begin
        if (i_cmd.dev) begin
            r_dev <= (s_amag >= s_grav) ? (s_amag - s_grav) : (s_grav - s_amag);
        end
        if (i_cmd.mul_a) begin
            r_sprod <= imag_pkg::SPROD_W'(r_dev) * imag_pkg::SPROD_W'(r_accel_w);
        end
        if (i_cmd.mul_g) begin
            r_score <= imag_pkg::SCORE_W'(r_sprod);
            r_sprod <= imag_pkg::SPROD_W'(r_root[1]) * imag_pkg::SPROD_W'(r_gyro_w);
        end
        if (i_cmd.sum) begin
            r_score <= r_score + imag_pkg::SCORE_W'(r_sprod);
        end
    end

    // Conductance scaling, settles well before the commit
    always_ff @(posedge i_clk) begin
        r_cx  <= imag_pkg::CX_W'(r_code) * imag_pkg::CX_W'(imag_pkg::MV_NUM);
        r_cmv <= imag_pkg::MV_W'((imag_pkg::CPROD_W'(r_cx) *
                 imag_pkg::CPROD_W'(imag_pkg::MV_RECIP)) >> imag_pkg::MV_SHIFT);
    end

    // Motion decision and hold-off counter
    assign s_motion = (r_score > imag_pkg::SCORE_W'(r_threshold));
    assign s_hold   = s_motion ? r_holdoff : r_hcnt;
    assign s_art    = (s_hold != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt <= '0;
        end else if (i_cmd.commit) begin
            r_hcnt <= s_art ? (s_hold - 1'b1) : s_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_motion   <= s_motion;
            r_artifact <= s_art;
            r_left     <= s_art ? (s_hold - 1'b1) : s_hold;
            r_mv       <= r_cmv;
        end
    end

    assign o_motion_hit     = r_motion;
    assign o_artifact_flag  = r_artifact;
    assign o_holdoff_left   = r_left;
    assign o_conductance_mv = r_mv;

endmodule

>>> design/imu_motion_artifact_gate_unit.sv
// IMU motion-artifact gate.
// i_smp carries one beat per IMU sample: three accelerometer axes, three
// gyroscope axes and a 12-bit skin-conductance code. o_res returns one beat
// per sample: motion flag, artifact flag, hold-off count left and the
// conductance in millivolts. Both channels use valid/ready.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes gravity
// level, the two Q16 weights, the Q16 threshold and the hold-off length;
// write it only while no sample is in flight.
// One sample is worked on at a time. Its result becomes valid in the same
// cycle that i_smp.ready rises again, so a new sample is taken only after
// the previous one is committed. In order: six squares through one shared
// multiplier, a load of the two bit-serial square root units, their steps
// one root bit at a time, the deviation and the score through one product
// register used twice, and the commit.
// The output register frees the input side: a new sample is accepted while
// the previous result waits. If the receiver stalls, the next result waits
// in its final step until the output register is taken.
// Reset is synchronous, active low: registers return to their defaults, the
// hold-off counter clears and no result is pending.
module imu_motion_artifact_gate_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    imag_smp_if.sink                         i_smp,
    imag_res_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [imag_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [imag_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    imag_pkg::t_dp_cmd              s_cmd;
    logic [imag_pkg::AXIS_W-1:0]    s_axis [imag_pkg::NUM_AXES];

    assign s_axis[0] = i_smp.accel_x;
    assign s_axis[1] = i_smp.accel_y;
    assign s_axis[2] = i_smp.accel_z;
    assign s_axis[3] = i_smp.rate_x;
    assign s_axis[4] = i_smp.rate_y;
    assign s_axis[5] = i_smp.rate_z;

    imag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (i_smp.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (s_cmd)
    );

    imag_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (s_cmd),
        .i_axis           (s_axis),
        .i_code           (i_smp.conductance_code),
        .o_motion_hit     (o_res.motion_hit),
        .o_artifact_flag  (o_res.artifact_flag),
        .o_holdoff_left   (o_res.holdoff_left),
        .o_conductance_mv (o_res.conductance_mv)
    );

endmodule

>>> design/imag_checker.sv
module imag_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    imag_smp_if.sink    i_smp,
    imag_res_if.source  o_res
);

    // A stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.motion_hit) &&
        $stable(o_res.artifact_flag) && $stable(o_res.holdoff_left) &&
        $stable(o_res.conductance_mv))
        else $error("result beat changed while stalled");

    // One sample in work at a time
    a_one_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_smp.valid && i_smp.ready |=> !i_smp.ready)
        else $error("sample accepted while another is in work");

    // Outside the hold-off window the counter is empty
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.artifact_flag |-> o_res.holdoff_left == '0)
        else $error("hold-off count left without artifact flag");

    // Conductance stays within full scale
    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.conductance_mv <= imag_pkg::MV_W'(imag_pkg::MV_FULL))
        else $error("conductance beyond full scale");

endmodule

bind imu_motion_artifact_gate_unit imag_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_smp   (i_smp),
    .o_res   (o_res)
);
